// ===== hdl/assert_macros.svh =====
// Assertion helpers shared by the RTL. Every check is sampled on the rising
// clock edge and is switched off while the synchronous reset is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition must hold at every sampled edge.
`define ASSERT_ALWAYS(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("assertion failed: invariant");

// When the trigger holds, the consequence must hold in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst_n, trig, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// When the trigger holds, the consequence must hold in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, trig, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// ===== hdl/yuv_pkg.sv =====
package yuv_pkg;

  // Signed width of every channel sum, wide enough for all byte patterns.
  localparam int SUM_W = 20;
  // Offset luma and chroma samples, signed.
  localparam int SMP_W = 9;

  localparam int MID_DEPTH_DEF = 2;
  localparam int OUT_DEPTH_DEF = 2;

  // Byte order codes of the configuration register.
  localparam logic ORDER_UYVY = 1'b0;
  localparam logic ORDER_YUYV = 1'b1;

  // BT.601 integer coefficients and offsets.
  localparam logic signed [SUM_W-1:0] K_Y     = 20'sd298;
  localparam logic signed [SUM_W-1:0] K_RV    = 20'sd409;
  localparam logic signed [SUM_W-1:0] K_GU    = 20'sd100;
  localparam logic signed [SUM_W-1:0] K_GV    = 20'sd208;
  localparam logic signed [SUM_W-1:0] K_BU    = 20'sd516;
  localparam logic signed [SUM_W-1:0] K_ROUND = 20'sd128;
  localparam logic signed [SMP_W-1:0] Y_OFS   = 9'sd16;
  localparam logic signed [SMP_W-1:0] C_OFS   = 9'sd128;

  typedef logic signed [SUM_W-1:0] sum_t;
  typedef logic signed [SMP_W-1:0] smp_t;

  // One macropixel after the front end: both lumas and the chroma terms.
  typedef struct packed {
    smp_t y0;
    smp_t y1;
    sum_t r_term;
    sum_t g_term;
    sum_t b_term;
    logic frame_end;
  } mpix_t;

  // One finished RGB pixel.
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       pair_last;
    logic       frame_end;
  } pix_t;

endpackage

// ===== hdl/yuv422_to_rgb888.sv =====
// YUV 4:2:2 to RGB888 converter, BT.601 integer coefficients. Each request on
// the input queue carries one packed macropixel of four bytes; it yields two
// RGB pixels, the first built from Y0 and the second from Y1, both sharing the
// macropixel's U and V. cfg_data written with cfg_we selects the byte order:
// 0 (the reset value) means U Y0 V Y1, 1 means Y0 U Y1 V. Only write it while
// no request is in flight. Each channel is (298*Y + chroma term + 128) >> 8
// with Y offset by 16 and U, V by 128, clamped to 0..255. The second pixel has
// out_pair_last set and carries the request's frame end flag; the first pixel
// always shows frame end low. Throughput is one pixel per cycle while the
// output queue has room, set by the single per-pixel datapath in the back
// end, which handles the two pixels of a macropixel in turn. The first pixel
// of a request is registered in the macropixel queue and then in the output
// queue before it shows on the output ports. Reset is synchronous and active
// low.
`include "assert_macros.svh"

module yuv422_to_rgb888 #(
  parameter int MID_DEPTH = yuv_pkg::MID_DEPTH_DEF,
  parameter int OUT_DEPTH = yuv_pkg::OUT_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic       cfg_data,
  input  logic       in_push,
  output logic       in_full,
  input  logic [7:0] in_byte_a,
  input  logic [7:0] in_byte_b,
  input  logic [7:0] in_byte_c,
  input  logic [7:0] in_byte_d,
  input  logic       in_frame_end_in,
  output logic       out_empty,
  input  logic       out_pop,
  output logic [7:0] out_red,
  output logic [7:0] out_green,
  output logic [7:0] out_blue,
  output logic       out_pair_last,
  output logic       out_frame_end_out
);

  import yuv_pkg::*;

  // Front end: reorders the bytes, removes the offsets and forms the three
  // chroma products once per macropixel.
  mpix_t front_entry;
  // Macropixel queue between the front and back ends.
  mpix_t mid_entry;
  logic  mid_empty, mid_pop;
  // Back end result and output queue.
  pix_t  back_pixel, out_pixel;
  logic  back_push, out_full;

  yuv_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .byte_a    (in_byte_a),
    .byte_b    (in_byte_b),
    .byte_c    (in_byte_c),
    .byte_d    (in_byte_d),
    .frame_end (in_frame_end_in),
    .entry     (front_entry)
  );

  // A request is accepted whenever the macropixel queue has room, so the
  // front end keeps taking input while finished pixels wait at the output.
  yuv_fifo #(
    .WIDTH ($bits(mpix_t)),
    .DEPTH (MID_DEPTH)
  ) u_mid_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_push),
    .wdata (front_entry),
    .full  (in_full),
    .pop   (mid_pop),
    .rdata (mid_entry),
    .empty (mid_empty)
  );

  // Back end: one pixel per cycle while the output queue has room, two pixels per queued macropixel.
  yuv_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .entry     (mid_entry),
    .mid_empty (mid_empty),
    .mid_pop   (mid_pop),
    .out_full  (out_full),
    .out_push  (back_push),
    .pixel     (back_pixel)
  );

  // The output queue registers each pixel and decouples the consumer.
  yuv_fifo #(
    .WIDTH ($bits(pix_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (back_push),
    .wdata (back_pixel),
    .full  (out_full),
    .pop   (out_pop),
    .rdata (out_pixel),
    .empty (out_empty)
  );

  assign out_red           = out_pixel.red;
  assign out_green         = out_pixel.green;
  assign out_blue          = out_pixel.blue;
  assign out_pair_last     = out_pixel.pair_last;
  assign out_frame_end_out = out_pixel.frame_end;

endmodule

// ===== hdl/yuv_fifo.sv =====
`include "assert_macros.svh"

module yuv_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wptr_r, wptr_nxt;
  logic [AW-1:0]    rptr_r, rptr_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rptr_r];

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (do_push) begin
      wptr_nxt = (wptr_r == AW'(DEPTH - 1)) ? '0 : wptr_r + 1'b1;
    end
    if (do_pop) begin
      rptr_nxt = (rptr_r == AW'(DEPTH - 1)) ? '0 : rptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wptr_r] <= wdata;
    end
  end

  `ASSERT_ALWAYS(a_cnt_bound, clk, rst_n, cnt_r <= CW'(DEPTH))
  `ASSERT_NEXT(a_cnt_up, clk, rst_n, do_push && !do_pop, cnt_r == $past(cnt_r) + 1'b1)
  `ASSERT_NEXT(a_cnt_down, clk, rst_n, do_pop && !do_push, cnt_r == $past(cnt_r) - 1'b1)

endmodule

// ===== hdl/yuv_front.sv =====
module yuv_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_we,
  input  logic          cfg_data,
  input  logic [7:0]    byte_a,
  input  logic [7:0]    byte_b,
  input  logic [7:0]    byte_c,
  input  logic [7:0]    byte_d,
  input  logic          frame_end,
  output yuv_pkg::mpix_t entry
);

  import yuv_pkg::*;

  logic       order_r;
  logic [7:0] y0_raw, y1_raw, u_raw, v_raw;
  smp_t       cb, cr;
  sum_t       cb_w, cr_w;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      order_r <= ORDER_UYVY;
    end else if (cfg_we) begin
      order_r <= cfg_data;
    end
  end

  always_comb begin
    unique case (order_r)
      ORDER_YUYV: begin
        y0_raw = byte_a;
        u_raw  = byte_b;
        y1_raw = byte_c;
        v_raw  = byte_d;
      end
      default: begin
        u_raw  = byte_a;
        y0_raw = byte_b;
        v_raw  = byte_c;
        y1_raw = byte_d;
      end
    endcase
  end

  // Offset removal keeps every sample in nine signed bits.
  assign cb   = $signed({1'b0, u_raw}) - C_OFS;
  assign cr   = $signed({1'b0, v_raw}) - C_OFS;
  assign cb_w = SUM_W'(cb);
  assign cr_w = SUM_W'(cr);

  assign entry.y0        = $signed({1'b0, y0_raw}) - Y_OFS;
  assign entry.y1        = $signed({1'b0, y1_raw}) - Y_OFS;
  assign entry.r_term    = K_RV * cr_w;
  assign entry.g_term    = -(K_GU * cb_w) - K_GV * cr_w;
  assign entry.b_term    = K_BU * cb_w;
  assign entry.frame_end = frame_end;

endmodule

// ===== hdl/yuv_back.sv =====
`include "assert_macros.svh"

module yuv_back (
  input  logic           clk,
  input  logic           rst_n,
  input  yuv_pkg::mpix_t entry,
  input  logic           mid_empty,
  output logic           mid_pop,
  input  logic           out_full,
  output logic           out_push,
  output yuv_pkg::pix_t  pixel
);

  import yuv_pkg::*;

  logic phase_r, phase_nxt;
  smp_t y_sel;
  sum_t ys, r_sum, g_sum, b_sum;

  function automatic logic [7:0] clamp8(input sum_t s);
    logic [7:0] res;
    if (s[SUM_W-1]) begin
      res = 8'd0;
    end else if (s[SUM_W-2:16] != '0) begin
      res = 8'hFF;
    end else begin
      res = s[15:8];
    end
    return res;
  endfunction

  assign y_sel = phase_r ? entry.y1 : entry.y0;
  assign ys    = K_Y * SUM_W'(y_sel) + K_ROUND;
  assign r_sum = ys + entry.r_term;
  assign g_sum = ys + entry.g_term;
  assign b_sum = ys + entry.b_term;

  assign pixel.red       = clamp8(r_sum);
  assign pixel.green     = clamp8(g_sum);
  assign pixel.blue      = clamp8(b_sum);
  assign pixel.pair_last = phase_r;
  assign pixel.frame_end = phase_r & entry.frame_end;

  assign out_push  = !mid_empty && !out_full;
  assign mid_pop   = out_push && phase_r;
  assign phase_nxt = out_push ? !phase_r : phase_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
    end
  end

  `ASSERT_IMPLIES(a_pop_second, clk, rst_n, mid_pop, out_push && phase_r)
  `ASSERT_IMPLIES(a_half_done, clk, rst_n, phase_r, !mid_empty)
  `ASSERT_NEXT(a_first_then_second, clk, rst_n, out_push && !phase_r, phase_r)

endmodule
